### src/crcmb_pkg.sv
// Shared types, constants and CRC helper functions for the CRC-16/MODBUS frame checker.
`timescale 1ns / 1ps

package crcmb_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CrcW  = 16;

  localparam logic [CrcW-1:0] CrcInit = 16'hFFFF;
  localparam logic [CrcW-1:0] CrcPoly = 16'hA001;

  // Mode register values.
  localparam logic ModeCalc  = 1'b0;
  localparam logic ModeCheck = 1'b1;

  // Number of bytes held back as the trailer in check mode.
  localparam logic [1:0] DelayFull = 2'd3;
  localparam logic [1:0] DelayTwo  = 2'd2;

  // One input beat as it sits in the input register.
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             frame_end;
  } beat_t;

  // One result as it sits in the output register.
  typedef struct packed {
    logic             check_passed;
    logic [CrcW-1:0]  crc_value;
  } result_t;

  // Fold one byte into the running CRC, LSB first, reflected polynomial.
  function automatic logic [CrcW-1:0] crc_fold(input logic [CrcW-1:0] crc,
                                               input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {{(CrcW-ByteW){1'b0}}, b};
    for (int i = 0; i < ByteW; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // Swap the two bytes of the CRC for reporting.
  function automatic logic [CrcW-1:0] crc_swap(input logic [CrcW-1:0] crc);
    return {crc[ByteW-1:0], crc[CrcW-1:ByteW]};
  endfunction

endpackage

### src/crcmb_in_stage.sv
// Input register that holds one accepted byte beat until the engine consumes it.
`timescale 1ns / 1ps

module crcmb_in_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] data_byte
  input  logic                  s_tlast,   // frame_end
  input  logic                  advance,
  output logic                  beat_valid,
  output crcmb_pkg::beat_t      beat
);
  import crcmb_pkg::*;

  logic  valid;
  beat_t held;

  // The register takes a new beat when empty or when its beat moves on.
  assign s_tready   = !valid || advance;
  assign beat_valid = valid;
  assign beat       = held;

  // Valid flag of the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  // Payload of the input register.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      held.data_byte <= s_tdata[ByteW-1:0];
      held.frame_end <= s_tlast;
    end
  end

endmodule

### src/crcmb_engine.sv
// Frame state, CRC update and trailer compare for one beat per cycle while beats advance.
`timescale 1ns / 1ps

module crcmb_engine (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic                  cfg_mode,
  input  logic                  step,
  input  crcmb_pkg::beat_t      beat,
  output logic                  result_valid,
  output crcmb_pkg::result_t    result
);
  import crcmb_pkg::*;

  logic             mode;
  logic [CrcW-1:0]  crc;
  logic [ByteW-1:0] delay [3];
  logic [1:0]       seen;

  logic [CrcW-1:0]  crc_next;
  logic [ByteW-1:0] fold_src;
  logic             fold_en;
  logic [CrcW-1:0]  crc_swapped;
  logic             trailer_match;

  // Choose which byte is folded: the fresh byte, or the oldest delayed byte.
  always_comb begin
    if (mode == ModeCheck) begin
      fold_src = delay[0];
      fold_en  = (seen == DelayFull);
    end else begin
      fold_src = beat.data_byte;
      fold_en  = 1'b1;
    end
    crc_next      = fold_en ? crc_fold(crc, fold_src) : crc;
    crc_swapped   = crc_swap(crc_next);
    trailer_match = (crc_swapped == {delay[1], delay[2]});
  end

  // A result leaves on every frame end.
  assign result_valid        = step && beat.frame_end;
  assign result.crc_value    = crc_swapped;
  assign result.check_passed = (mode == ModeCheck) && (seen >= DelayTwo) && trailer_match;

  // Mode register; a write restarts the frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= ModeCalc;
    end else if (cfg_write) begin
      mode <= cfg_mode;
    end
  end

  // Running CRC, trailer delay and byte count; all restart on reset, a mode write or a frame end.
  always_ff @(posedge clk) begin
    if (rst || cfg_write || (step && beat.frame_end)) begin
      crc      <= CrcInit;
      delay[0] <= '0;
      delay[1] <= '0;
      delay[2] <= '0;
      seen     <= '0;
    end else if (step) begin
      crc <= crc_next;
      if (mode == ModeCheck) begin
        delay[0] <= delay[1];
        delay[1] <= delay[2];
        delay[2] <= beat.data_byte;
        if (seen != DelayFull) begin
          seen <= seen + 2'd1;
        end
      end
    end
  end

endmodule

### src/crcmb_out_stage.sv
// Output register that holds one result beat until the downstream side takes it.
`timescale 1ns / 1ps

module crcmb_out_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  crcmb_pkg::result_t    result,
  output logic                  can_load,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [23:0]           m_tdata    // [15:0] crc_value, [16] check_passed, rest zero
);
  import crcmb_pkg::*;

  logic    valid;
  result_t held;

  // A new result may enter when the register is empty or is being drained.
  assign can_load = !valid || m_tready;
  assign m_tvalid = valid;
  assign m_tdata  = {7'd0, held.check_passed, held.crc_value};

  // Valid flag of the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_load) begin
      valid <= load;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load && can_load) begin
      held <= result;
    end
  end

endmodule

### src/crc16_modbus_frame_check.sv
// Top level of the CRC-16/MODBUS frame calculator and checker.
// One frame byte per beat enters on the slave side, with tlast on the last byte
// of the frame, and one result beat leaves on the master side per frame end. The
// block takes one byte per clock cycle unless a stall holds it: the eight-bit CRC
// update and trailer compare run while a byte sits in the input register, and
// the result is captured in the output register when the end byte leaves the
// input register, and the result beat is presented on the master side from the
// output register. An end byte waits in the input register while the output
// register still holds a result that has not been taken, and the slave side
// stalls with it. In calculate mode (mode 0) every byte is covered and
// the byte-swapped CRC is reported with check_passed 0. In check mode (mode 1)
// the last three bytes are held back: the third-last and second-last bytes are
// the received CRC low and high bytes, the end byte is ignored, and check_passed
// says whether they match; frames under three bytes fail. Writing the mode
// register restarts the frame and should only be done while no frame is in flight.
`timescale 1ns / 1ps

module crc16_modbus_frame_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,   // mode
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] data_byte
  input  logic        s_tlast,    // frame_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata     // [15:0] crc_value, [16] check_passed, rest zero
);
  import crcmb_pkg::*;

  logic    beat_valid;
  beat_t   beat;
  logic    advance;
  logic    can_load;
  logic    result_valid;
  result_t result;
  logic    cfg_write;

  // The mode register is always writable.
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // A beat moves on unless it ends a frame and the output register is blocked.
  assign advance = beat_valid && (!beat.frame_end || can_load);

  crcmb_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .advance    (advance),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

  crcmb_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_mode     (cfg_data),
    .step         (advance),
    .beat         (beat),
    .result_valid (result_valid),
    .result       (result)
  );

  crcmb_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (result_valid),
    .result   (result),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

### verif/testbench.sv
// Self-checking testbench for the CRC-16/MODBUS frame calculator and checker.
`timescale 1ns / 1ps

module testbench;

  import crcmb_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  // One result beat as the scoreboard holds it.
  typedef struct {
    logic [15:0] crc_value;
    logic        check_passed;
  } frame_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;     // mode
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;     // [7:0] data_byte
  logic        s_tlast = 1'b0;      // frame_end
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;             // [15:0] crc_value, [16] check_passed, rest zero

  // Shadow copy of the frame state inside the block.
  logic        fm_mode;
  logic [15:0] fm_crc;
  logic [7:0]  fm_hold [3];
  logic [1:0]  fm_held;

  frame_result_t results_due[$];
  int          error_count = 0;
  int          beats_sent = 0;
  bit          idle_on = 1'b1;
  int          stall_left = 0;

  crc16_modbus_frame_check DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // Clock generation.
  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #4_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  // One byte through the CRC register, LSB first.
  function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {8'h00, b};
    repeat (8) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  // Start a new frame in the shadow state.
  function automatic void frame_restart();
    fm_crc = CrcInit;
    fm_hold[0] = 8'h00;
    fm_hold[1] = 8'h00;
    fm_hold[2] = 8'h00;
    fm_held = 2'd0;
  endfunction

  // Advance the shadow state by one accepted byte and queue the result on a frame end.
  function automatic void frame_model_byte(input logic [7:0] b, input logic last);
    frame_result_t r;
    if (fm_mode == ModeCalc) begin
      fm_crc = crc16_step(fm_crc, b);
      if (!last) return;
      r.check_passed = 1'b0;
    end else begin
      if (!last) begin
        if (fm_held == 2'd3) fm_crc = crc16_step(fm_crc, fm_hold[0]);
        fm_hold[0] = fm_hold[1];
        fm_hold[1] = fm_hold[2];
        fm_hold[2] = b;
        if (fm_held != 2'd3) fm_held = fm_held + 2'd1;
        return;
      end
      // The end byte itself is not used in check mode.
      if (fm_held == 2'd3) fm_crc = crc16_step(fm_crc, fm_hold[0]);
      r.check_passed = (fm_held >= 2'd2) &&
                       ({fm_crc[7:0], fm_crc[15:8]} == {fm_hold[1], fm_hold[2]});
    end
    r.crc_value = {fm_crc[7:0], fm_crc[15:8]};
    results_due.push_back(r);
    frame_restart();
  endfunction

  // Result side: random stall bursts while idling is enabled.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      m_tready <= 1'b0;
      stall_left <= $urandom_range(0, 14);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Compare every accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    frame_result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %h", $time, m_tdata);
        error_count++;
      end else begin
        exp_r = results_due.pop_front();
        if (m_tdata[15:0] !== exp_r.crc_value) begin
          $display("%0t: crc_value mismatch, expected %h, actual %h",
                   $time, exp_r.crc_value, m_tdata[15:0]);
          error_count++;
        end
        if (m_tdata[16] !== exp_r.check_passed) begin
          $display("%0t: check_passed mismatch, expected %b, actual %b",
                   $time, exp_r.check_passed, m_tdata[16]);
          error_count++;
        end
        if (m_tdata[23:17] !== 7'd0) begin
          $display("%0t: padding mismatch, expected %h, actual %h",
                   $time, 7'd0, m_tdata[23:17]);
          error_count++;
        end
      end
    end
  end

  // Send one frame byte, with an optional idle gap before it.
  task automatic send_beat(input logic [7:0] b, input logic last);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    frame_model_byte(b, last);
    beats_sent++;
  endtask

  // Send a whole frame, tlast on the final byte.
  task automatic send_frame(input byte_q_t f);
    foreach (f[i]) send_beat(f[i], i == f.size() - 1);
  endtask

  // Stop sending and let every expected result come back.
  task automatic drain();
    s_tvalid <= 1'b0;
    for (int i = 0; i < 5000 && results_due.size() != 0; i++) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the mode register once the block is idle.
  task automatic write_mode(input logic m);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    fm_mode = m;
    frame_restart();
  endtask

  // A payload followed by its correct swapped CRC trailer and an end byte.
  function automatic byte_q_t framed_payload(input int len);
    byte_q_t f;
    logic [15:0] acc;
    logic [7:0] b;
    acc = CrcInit;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      f.push_back(b);
      acc = crc16_step(acc, b);
    end
    f.push_back(acc[7:0]);
    f.push_back(acc[15:8]);
    f.push_back(8'($urandom));
    return f;
  endfunction

  function automatic byte_q_t random_bytes(input int len);
    byte_q_t f;
    for (int i = 0; i < len; i++) f.push_back(8'($urandom));
    return f;
  endfunction

  function automatic int random_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 48) : $urandom_range(0, 6);
  endfunction

  // Random check-mode frame: mostly well formed, some corrupted, some noise.
  task automatic random_check_frame();
    byte_q_t f;
    int kind;
    int idx;
    kind = $urandom_range(0, 99);
    if (kind < 85) begin
      f = framed_payload(random_len());
      if (kind >= 70) begin
        idx = $urandom_range(0, f.size() - 2);
        f[idx] = f[idx] ^ (8'h01 << $urandom_range(0, 7));
      end
    end else begin
      f = random_bytes($urandom_range(1, 5));
    end
    send_frame(f);
  endtask

  task automatic random_calc_frame();
    send_frame(random_bytes(random_len() + 1));
  endtask

  // Calculate mode straight out of reset: extremes and a short string.
  task automatic test_calc_directed();
    send_frame({8'h00});
    send_frame({8'hFF});
    send_frame({8'h31, 8'h32, 8'h33});
  endtask

  // Check mode: short frames, three-byte frames, a good and a bad trailer.
  task automatic test_check_directed();
    byte_q_t f;
    write_mode(ModeCheck);
    send_frame({8'hAA});
    send_frame({8'h11, 8'h22});
    send_frame({8'hFF, 8'hFF, 8'h00});
    send_frame({8'h12, 8'h34, 8'h56});
    f = framed_payload(2);
    send_frame(f);
    f[3] = f[3] ^ 8'h80;
    send_frame(f);
  endtask

  // A mode write in the middle of a frame throws the partial frame away.
  task automatic test_mode_write_restart();
    send_beat(8'h55, 1'b0);
    send_beat(8'h66, 1'b0);
    write_mode(ModeCalc);
    send_frame({8'h01});
  endtask

  task automatic test_random_calc(input int n);
    int stop_at;
    write_mode(ModeCalc);
    stop_at = beats_sent + n;
    while (beats_sent < stop_at) begin
      idle_on = ($urandom_range(0, 4) != 0);
      random_calc_frame();
    end
  endtask

  task automatic test_random_check(input int n);
    int stop_at;
    write_mode(ModeCheck);
    stop_at = beats_sent + n;
    while (beats_sent < stop_at) begin
      idle_on = ($urandom_range(0, 4) != 0);
      random_check_frame();
    end
  endtask

  // Frames in both modes with mode writes between them, some cutting a frame short.
  task automatic test_random_mode_mix(input int n);
    int stop_at;
    stop_at = beats_sent + n;
    while (beats_sent < stop_at) begin
      idle_on = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 7) == 0) begin
        if ($urandom_range(0, 2) == 0) begin
          repeat ($urandom_range(1, 4)) send_beat(8'($urandom), 1'b0);
        end
        write_mode(1'($urandom_range(0, 1)));
      end
      if (fm_mode == ModeCheck) random_check_frame();
      else random_calc_frame();
    end
  endtask

  // Full-rate traffic with no idling on either side.
  task automatic test_back_to_back(input int n);
    int stop_at;
    drain();
    idle_on = 1'b0;
    stop_at = beats_sent + n;
    while (beats_sent < stop_at) begin
      if (fm_mode == ModeCheck) random_check_frame();
      else random_calc_frame();
    end
  endtask

  // Test sequence.
  initial begin
    fm_mode = ModeCalc;
    frame_restart();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_calc_directed();
    test_check_directed();
    test_mode_write_restart();
    test_random_calc(600);
    test_random_check(700);
    test_random_mode_mix(500);
    test_back_to_back(200);

    drain();
    repeat (8) @(posedge clk);
    while (results_due.size() != 0) begin
      $display("%0t: missing result, expected %h/%b, actual none",
               $time, results_due[0].crc_value, results_due[0].check_passed);
      void'(results_due.pop_front());
      error_count++;
    end
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
src/crcmb_pkg.sv
src/crcmb_in_stage.sv
src/crcmb_engine.sv
src/crcmb_out_stage.sv
src/crc16_modbus_frame_check.sv
verif/testbench.sv
